// File: rtl/ebid_pkg.sv
// Shared types, constants and header helpers for the build-id note scanner.
package ebid_pkg;

	localparam int MAX_ID_BYTES  = 64;
	localparam int ID_IDX_W      = (MAX_ID_BYTES > 1) ? $clog2(MAX_ID_BYTES) : 1;
	localparam int ID_POS_W      = 6;
	localparam int ID_LEN_W      = 7;
	localparam int HDR_LEN       = 12;
	localparam int OFF_W         = 34;
	localparam int NAME_CHK_END  = HDR_LEN + 4;
	localparam logic [31:0] BUILD_ID_TYPE = 32'd3;
	localparam logic [31:0] GNU_NAME_SZ   = 32'd4;

	typedef logic [HDR_LEN-1:0][7:0] hdr_t;

	typedef struct packed {
		logic [7:0] note_byte;
		logic       object_start;
		logic       segment_end;
	} note_item_t;

	typedef struct packed {
		logic [7:0]          id_byte;
		logic [ID_POS_W-1:0] id_position;
		logic [ID_LEN_W-1:0] id_length;
		logic                id_last;
	} id_item_t;

	typedef struct packed {
		logic                en;
		logic [ID_IDX_W-1:0] idx;
		logic [7:0]          data;
	} id_wr_t;

	typedef struct packed {
		logic                en;
		logic [ID_LEN_W-1:0] len;
	} id_launch_t;

	function automatic logic [31:0] hdr_word(hdr_t h, logic [1:0] w, logic be);
		int base;
		base = int'(w) * 4;
		if (be) begin
			return {h[base], h[base+1], h[base+2], h[base+3]};
		end
		return {h[base+3], h[base+2], h[base+1], h[base]};
	endfunction

	// round up to a multiple of 4 without wrapping at 32 bits
	function automatic logic [32:0] pad4(logic [31:0] v);
		return ({1'b0, v} + 33'd3) & ~33'd3;
	endfunction

	function automatic logic [7:0] gnu_byte(logic [1:0] i);
		logic [7:0] r;
		case (i)
			2'd0:    r = 8'h47;
			2'd1:    r = 8'h4E;
			2'd2:    r = 8'h55;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/ebid_if.sv
// Valid/ready channel interfaces for note bytes in and identifier bytes out.
interface ebid_note_if import ebid_pkg::*; ();
	logic       valid;
	logic       ready;
	note_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface ebid_id_if import ebid_pkg::*; ();
	logic     valid;
	logic     ready;
	id_item_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: rtl/ebid_id_store.sv
// Identifier byte RAM with burst read sequencer and a two-entry output queue.
module ebid_id_store import ebid_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  id_wr_t     wr,
	input  id_launch_t launch,
	output logic       busy,
	ebid_id_if.source  id_out
);

	logic [7:0]          mem [MAX_ID_BYTES];

	logic                burst_active_q;
	logic [ID_IDX_W-1:0] rd_idx_q;
	logic [ID_LEN_W-1:0] len_q;

	logic                rd_valid_s1;
	logic [7:0]          rd_data_s1;
	logic [ID_IDX_W-1:0] rd_idx_s1;
	logic [ID_LEN_W-1:0] len_s1;
	logic                last_s1;

	id_item_t            fifo_q [2];
	logic                wr_ptr_q;
	logic                rd_ptr_q;
	logic [1:0]          cnt_q;

	logic                pop;
	logic                push;
	logic                issue;
	logic                rd_last;
	logic [1:0]          occ;
	id_item_t            push_item;

	always_comb begin
		pop     = id_out.valid && id_out.ready;
		push    = rd_valid_s1;
		occ     = cnt_q + {1'b0, rd_valid_s1};
		// room counts the entry leaving this cycle
		issue   = burst_active_q && (occ <= (2'd1 + {1'b0, pop}));
		rd_last = (ID_LEN_W'(rd_idx_q) + ID_LEN_W'(1)) == len_q;
		push_item.id_byte     = rd_data_s1;
		push_item.id_position = ID_POS_W'(rd_idx_s1);
		push_item.id_length   = len_s1;
		push_item.id_last     = last_s1;
	end

	assign busy         = burst_active_q;
	assign id_out.valid = cnt_q != 2'd0;
	assign id_out.data  = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.data;
		end
		if (issue) begin
			rd_data_s1 <= mem[rd_idx_q];
			rd_idx_s1  <= rd_idx_q;
			len_s1     <= len_q;
			last_s1    <= rd_last;
		end
		if (push) begin
			fifo_q[wr_ptr_q] <= push_item;
		end
		if (launch.en) begin
			len_q <= launch.len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_active_q <= 1'b0;
			rd_idx_q       <= '0;
			rd_valid_s1    <= 1'b0;
			wr_ptr_q       <= 1'b0;
			rd_ptr_q       <= 1'b0;
			cnt_q          <= 2'd0;
		end else begin
			rd_valid_s1 <= issue;
			if (launch.en) begin
				burst_active_q <= 1'b1;
				rd_idx_q       <= '0;
			end else if (issue) begin
				if (rd_last) begin
					burst_active_q <= 1'b0;
				end else begin
					rd_idx_q <= rd_idx_q + ID_IDX_W'(1);
				end
			end
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// File: rtl/elf_build_id_note_scanner.sv
// Build-id note scanner: takes one note byte per cycle with no gaps of its own. Each note's
// first 64 descriptor bytes are written to a 64-entry RAM as they pass; on a matching note's
// last padded byte a burst of up to 64 identifier bytes is read from that RAM, one per cycle
// while the two-entry output queue has room, each byte going through a read register into it.
// While the burst drains the rest of the object is ignored and bytes keep flowing; only a byte
// that starts a new object waits, until the burst has read its last byte, since it may
// overwrite the RAM being read.
module elf_build_id_note_scanner import ebid_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic      cfg_wdata,
	ebid_note_if.sink note_in,
	ebid_id_if.source id_out
);

	logic                big_endian_q;
	logic [OFF_W-1:0]    note_offset_q;
	logic                name_matches_q;
	logic                object_found_q;
	logic [7:0]          hdr_q [HDR_LEN];

	// bounds latched at the end of each header, for both word orders
	logic [OFF_W-1:0]    name_end_q [2];
	logic [OFF_W-1:0]    note_end_q [2];
	logic                hit_q [2];
	logic [ID_LEN_W-1:0] id_len_q [2];

	note_item_t          item;
	logic                fire;
	logic                store_busy;
	logic [OFF_W-1:0]    off;
	logic                found_eff;
	logic                nm_in;
	logic                nm_new;
	hdr_t                hdr_cur;
	logic [31:0]         namesz_c [2];
	logic [31:0]         descsz_c [2];
	logic [31:0]         type_c [2];
	logic [OFF_W-1:0]    name_end_c [2];
	logic [OFF_W-1:0]    note_end_c [2];
	logic                hit_c [2];
	logic [ID_LEN_W-1:0] id_len_c [2];
	logic                hdr_empty;
	logic [OFF_W-1:0]    ne;
	logic [OFF_W-1:0]    te;
	logic [OFF_W-1:0]    d_full;
	logic                in_name;
	logic                done;
	logic                in_body;
	logic                hdr_last;
	logic [OFF_W-1:0]    offset_d;
	logic                nm_d;
	logic                found_d;
	id_wr_t              wr;
	id_launch_t          launch;

	assign item          = note_in.data;
	assign note_in.ready = !store_busy || (object_found_q && !item.object_start);
	assign fire          = note_in.valid && note_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_endian_q <= 1'b0;
		end else if (cfg_we) begin
			big_endian_q <= cfg_wdata;
		end
	end

	always_comb begin
		off       = item.object_start ? '0 : note_offset_q;
		found_eff = object_found_q && !item.object_start;
		nm_in     = item.object_start || name_matches_q;

		for (int i = 0; i < HDR_LEN; i++) begin
			hdr_cur[i] = (i == HDR_LEN - 1) ? item.note_byte : hdr_q[i];
		end
		for (int e = 0; e < 2; e++) begin
			namesz_c[e]   = hdr_word(hdr_cur, 2'd0, 1'(e));
			descsz_c[e]   = hdr_word(hdr_cur, 2'd1, 1'(e));
			type_c[e]     = hdr_word(hdr_cur, 2'd2, 1'(e));
			name_end_c[e] = OFF_W'(HDR_LEN) + OFF_W'(pad4(namesz_c[e]));
			note_end_c[e] = name_end_c[e] + OFF_W'(pad4(descsz_c[e]));
			hit_c[e]      = (type_c[e] == BUILD_ID_TYPE) && (namesz_c[e] == GNU_NAME_SZ) &&
			                (descsz_c[e] != 32'd0);
			id_len_c[e]   = (descsz_c[e] >= 32'(MAX_ID_BYTES)) ? ID_LEN_W'(MAX_ID_BYTES)
			                                                   : ID_LEN_W'(descsz_c[e]);
		end
		// zero size words pad to zero in either byte order
		hdr_empty = hdr_cur[7:0] == '0;

		ne      = name_end_q[big_endian_q];
		te      = note_end_q[big_endian_q];
		in_name = off < ne;
		d_full  = off - ne;
		done    = (off + OFF_W'(1)) >= te;
		in_body = off >= OFF_W'(HDR_LEN);
		hdr_last = off == OFF_W'(HDR_LEN - 1);
		nm_new  = nm_in && !(in_name && (off < OFF_W'(NAME_CHK_END)) &&
		                     (item.note_byte != gnu_byte(off[1:0])));

		offset_d   = note_offset_q;
		nm_d       = name_matches_q;
		found_d    = object_found_q;
		wr.en      = 1'b0;
		wr.idx     = d_full[ID_IDX_W-1:0];
		wr.data    = item.note_byte;
		launch.en  = 1'b0;
		launch.len = id_len_q[big_endian_q];

		if (fire) begin
			if (item.object_start) begin
				found_d  = 1'b0;
				offset_d = '0;
				nm_d     = 1'b1;
			end
			if (found_eff) begin
				if (item.segment_end) begin
					offset_d = '0;
					nm_d     = 1'b1;
				end
			end else begin
				if (!in_body) begin
					nm_d = nm_in;
					if (hdr_last && hdr_empty) begin
						offset_d = '0;
						nm_d     = 1'b1;
					end else begin
						offset_d = off + OFF_W'(1);
					end
				end else begin
					nm_d  = nm_new;
					wr.en = !in_name && (d_full < OFF_W'(MAX_ID_BYTES));
					if (done) begin
						offset_d = '0;
						nm_d     = 1'b1;
						if (hit_q[big_endian_q] && nm_new) begin
							found_d   = 1'b1;
							launch.en = 1'b1;
						end
					end else begin
						offset_d = off + OFF_W'(1);
					end
				end
				if (item.segment_end) begin
					offset_d = '0;
					nm_d     = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			note_offset_q  <= '0;
			name_matches_q <= 1'b1;
			object_found_q <= 1'b0;
		end else begin
			note_offset_q  <= offset_d;
			name_matches_q <= nm_d;
			object_found_q <= found_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && !found_eff && !in_body) begin
			hdr_q[off[3:0]] <= item.note_byte;
		end
		if (fire && !found_eff && hdr_last) begin
			for (int e = 0; e < 2; e++) begin
				name_end_q[e] <= name_end_c[e];
				note_end_q[e] <= note_end_c[e];
				hit_q[e]      <= hit_c[e];
				id_len_q[e]   <= id_len_c[e];
			end
		end
	end

	ebid_id_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.launch (launch),
		.busy   (store_busy),
		.id_out (id_out)
	);

	// the RAM is never written while a burst is reading it
	assert property (@(posedge clk) disable iff (!arst_n) !(store_busy && wr.en))
		else $error("identifier RAM written during burst");

	assert property (@(posedge clk) disable iff (!arst_n) launch.en |-> !store_busy)
		else $error("burst launched while previous burst active");

	assert property (@(posedge clk) disable iff (!arst_n) launch.en |=> object_found_q)
		else $error("match not recorded for object");

	assert property (@(posedge clk) disable iff (!arst_n)
		(id_out.valid && id_out.data.id_last) |->
		(ID_LEN_W'(id_out.data.id_position) + ID_LEN_W'(1) == id_out.data.id_length))
		else $error("last flag not on final identifier byte");

endmodule

// File: tb/sv/elf_build_id_note_scanner_checker.sv
// Checker for the build-id note scanner: predicts identifier bytes and compares them.
module elf_build_id_note_scanner_checker import ebid_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       note_valid,
	input  logic       note_ready,
	input  note_item_t note_data,
	input  logic       id_valid,
	input  logic       id_ready,
	input  id_item_t   id_data,
	output int         outstanding,
	output int         mismatches
);

	localparam logic [31:0] NAME_TAG = 32'h474E5500;

	logic        words_big;
	logic [33:0] note_pos;
	logic [7:0]  hdr_q [HDR_LEN];
	logic        name_ok;
	logic [7:0]  id_mem [MAX_ID_BYTES];
	logic        id_seen;
	id_item_t    pending_id_bytes [$];

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
		mismatches++;
	endtask

	function automatic logic [31:0] hdr_field(input int w);
		if (words_big) begin
			return {hdr_q[w*4], hdr_q[w*4+1], hdr_q[w*4+2], hdr_q[w*4+3]};
		end
		return {hdr_q[w*4+3], hdr_q[w*4+2], hdr_q[w*4+1], hdr_q[w*4]};
	endfunction

	function automatic logic [33:0] round_up4(input logic [31:0] v);
		logic [33:0] s;
		s = {2'b00, v} + 34'd3;
		return {s[33:2], 2'b00};
	endfunction

	task automatic scan_note_byte(input note_item_t it);
		logic [33:0] nxt, rel, dpos, pn, pd, note_end;
		logic [31:0] nsz, dsz, ntyp;
		int          len;
		id_item_t    item;
		if (it.object_start) begin
			id_seen  = 1'b0;
			note_pos = '0;
			name_ok  = 1'b1;
		end
		// once an id went out, only segment_end matters until the next object
		if (id_seen) begin
			if (it.segment_end) begin
				note_pos = '0;
				name_ok  = 1'b1;
			end
			return;
		end
		nxt = note_pos + 34'd1;
		if (note_pos < HDR_LEN) hdr_q[note_pos[3:0]] = it.note_byte;
		if (nxt >= HDR_LEN) begin
			nsz      = hdr_field(0);
			dsz      = hdr_field(1);
			ntyp     = hdr_field(2);
			pn       = round_up4(nsz);
			pd       = round_up4(dsz);
			note_end = 34'(HDR_LEN) + pn + pd;
			if (note_pos >= HDR_LEN) begin
				rel = note_pos - 34'(HDR_LEN);
				if (rel < pn) begin
					if (rel < 4 && it.note_byte != NAME_TAG[31 - 8*rel[1:0] -: 8]) name_ok = 1'b0;
				end else begin
					dpos = rel - pn;
					if (dpos < MAX_ID_BYTES) id_mem[dpos[5:0]] = it.note_byte;
				end
			end
			if (nxt >= note_end) begin
				if (ntyp == BUILD_ID_TYPE && nsz == GNU_NAME_SZ && name_ok && dsz != 0) begin
					len = (dsz < MAX_ID_BYTES) ? int'(dsz) : MAX_ID_BYTES;
					for (int k = 0; k < len; k++) begin
						item.id_byte     = id_mem[k];
						item.id_position = ID_POS_W'(k);
						item.id_length   = ID_LEN_W'(len);
						item.id_last     = (k == len - 1);
						pending_id_bytes.push_back(item);
					end
					id_seen = 1'b1;
				end
				note_pos = '0;
				name_ok  = 1'b1;
			end else begin
				note_pos = nxt;
			end
		end else begin
			note_pos = nxt;
		end
		if (it.segment_end) begin
			note_pos = '0;
			name_ok  = 1'b1;
		end
	endtask

	task automatic check_id_byte(input id_item_t got);
		id_item_t want;
		if (pending_id_bytes.size() == 0) begin
			report_mismatch("id byte with none pending", int'(got.id_byte), -1);
			return;
		end
		want = pending_id_bytes.pop_front();
		if (got.id_byte !== want.id_byte)
			report_mismatch("id_byte", int'(got.id_byte), int'(want.id_byte));
		if (got.id_position !== want.id_position)
			report_mismatch("id_position", int'(got.id_position), int'(want.id_position));
		if (got.id_length !== want.id_length)
			report_mismatch("id_length", int'(got.id_length), int'(want.id_length));
		if (got.id_last !== want.id_last)
			report_mismatch("id_last", int'(got.id_last), int'(want.id_last));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			words_big  = 1'b0;
			note_pos   = '0;
			name_ok    = 1'b1;
			id_seen    = 1'b0;
			mismatches = 0;
			for (int i = 0; i < HDR_LEN; i++) hdr_q[i] = '0;
			pending_id_bytes.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) words_big = cfg_wdata;
			if (note_valid && note_ready) scan_note_byte(note_data);
			if (id_valid && id_ready) check_id_byte(id_data);
			outstanding <= pending_id_bytes.size();
		end
	end

endmodule

// File: tb/sv/elf_build_id_note_scanner_test.sv
// Top of the build-id note scanner testbench: clock, reset, note stimulus and verdict.
module elf_build_id_note_scanner_test;
	import ebid_pkg::*;

	typedef enum int {
		NK_BUILD_ID,
		NK_BAD_NAME,
		NK_NAME_SIZE,
		NK_BAD_TYPE,
		NK_NO_DESC,
		NK_EMPTY,
		NK_HUGE,
		NK_SHORT_HDR,
		NK_CUT_ID
	} note_kind_t;

	localparam logic [31:0] NAME_TAG       = 32'h474E5500;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          HOLD_OFF_LEN   = 150;
	localparam int          PHASE_ITEMS    = 70;
	localparam int          DIRECTED_ITEMS = 25;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	logic big_mode;
	logic tx_jitter;
	logic rx_jitter;
	int   hold_len;
	int   sent;
	int   quiet_cycles;
	int   outstanding;
	int   mismatches;

	logic [7:0] seg_q [$];

	ebid_note_if note_if();
	ebid_id_if   id_if();

	elf_build_id_note_scanner u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.note_in  (note_if),
		.id_out   (id_if)
	);

	elf_build_id_note_scanner_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.note_valid (note_if.valid),
		.note_ready (note_if.ready),
		.note_data  (note_if.data),
		.id_valid   (id_if.valid),
		.id_ready   (id_if.ready),
		.id_data    (id_if.data),
		.outstanding(outstanding),
		.mismatches (mismatches)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		if ((note_if.valid && note_if.ready) || (id_if.valid && id_if.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin : rx_side
		int   stall;
		logic hold_taken;
		hold_taken = 1'b0;
		id_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			stall = 0;
			if (hold_len != 0 && !hold_taken) begin
				stall      = hold_len;
				hold_taken = 1'b1;
			end else if (rx_jitter && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 10);
			end
			if (stall != 0) begin
				id_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			id_if.ready <= 1'b1;
		end
	end

	task automatic put_item(input logic [7:0] b, input logic st, input logic se);
		int gap;
		if (tx_jitter && $urandom_range(0, 5) == 0) begin
			note_if.valid <= 1'b0;
			gap = $urandom_range(1, 10);
			repeat (gap) @(posedge clk);
		end
		note_if.valid <= 1'b1;
		note_if.data  <= '{note_byte: b, object_start: st, segment_end: se};
		do @(posedge clk); while (!note_if.ready);
	endtask

	task automatic send_segment(input logic first_start, input logic close);
		int last;
		last = seg_q.size() - 1;
		foreach (seg_q[i]) put_item(seg_q[i], first_start && i == 0, close && i == last);
	endtask

	task automatic write_mode(input logic v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		big_mode  = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// stop offering, then wait for every id byte and some slack after it
	task automatic settle();
		note_if.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic note_kind_t pick_kind();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) return NK_BUILD_ID;
		if (r < 38) return NK_BAD_NAME;
		if (r < 46) return NK_NAME_SIZE;
		if (r < 54) return NK_BAD_TYPE;
		if (r < 61) return NK_NO_DESC;
		if (r < 70) return NK_EMPTY;
		if (r < 78) return NK_HUGE;
		if (r < 86) return NK_SHORT_HDR;
		return NK_CUT_ID;
	endfunction

	// appends one note to seg_q; cut means the segment has to end inside it
	task automatic add_note(input note_kind_t kind, input int desc_len, output logic cut);
		logic [31:0] hw [3];
		logic [7:0]  nb [$];
		logic [7:0]  b;
		int          pn, pd, keep, flip, extra;
		hw[0] = GNU_NAME_SZ;
		if (desc_len != 0) hw[1] = desc_len;
		else if ($urandom_range(0, 9) == 0) hw[1] = $urandom_range(60, 70);
		else hw[1] = $urandom_range(1, 20);
		hw[2] = BUILD_ID_TYPE;
		cut   = 1'b0;
		flip  = -1;
		case (kind)
			NK_BAD_NAME: flip = $urandom_range(0, 3);
			NK_NAME_SIZE: begin
				hw[0] = $urandom_range(0, 8);
				if (hw[0] == GNU_NAME_SZ) hw[0] = 32'd9;
				hw[1] = $urandom_range(1, 8);
			end
			NK_BAD_TYPE: begin
				hw[2] = $urandom_range(0, 1) ? $urandom() : 32'($urandom_range(0, 7));
				if (hw[2] == BUILD_ID_TYPE) hw[2] = 32'd1;
				hw[1] = $urandom_range(1, 8);
			end
			NK_NO_DESC: hw[1] = '0;
			NK_EMPTY: begin
				hw[0] = '0;
				hw[1] = '0;
				hw[2] = $urandom();
			end
			NK_HUGE: begin
				case ($urandom_range(0, 2))
					0:       hw[1] = 32'hFFFF_FFFD;
					1:       hw[1] = 32'hFFFF_FFFF;
					default: hw[1] = 32'h8000_0000 | $urandom();
				endcase
				if ($urandom_range(0, 1) != 0) hw[0] = $urandom();
				cut = 1'b1;
			end
			NK_SHORT_HDR, NK_CUT_ID: cut = 1'b1;
			default: ;
		endcase
		for (int k = 0; k < 3; k++)
			for (int i = 0; i < 4; i++)
				nb.push_back(big_mode ? hw[k][31 - 8*i -: 8] : hw[k][8*i +: 8]);
		if (kind == NK_HUGE) begin
			// sizes run far past any segment, so only a few body bytes follow
			extra = $urandom_range(0, 6);
			repeat (extra) nb.push_back(8'($urandom_range(0, 255)));
		end else begin
			pn = int'((hw[0] + 32'd3) & ~32'd3);
			pd = int'((hw[1] + 32'd3) & ~32'd3);
			for (int i = 0; i < pn; i++) begin
				b = (i < 4) ? NAME_TAG[31 - 8*i -: 8] : 8'($urandom_range(0, 255));
				if (i == flip) b = b ^ 8'($urandom_range(1, 255));
				nb.push_back(b);
			end
			for (int i = 0; i < pd; i++) nb.push_back(8'($urandom_range(0, 255)));
		end
		keep = nb.size();
		if (kind == NK_SHORT_HDR) keep = $urandom_range(1, HDR_LEN - 1);
		if (kind == NK_CUT_ID) keep = $urandom_range(1, nb.size() - 1);
		while (nb.size() > keep) void'(nb.pop_back());
		foreach (nb[i]) seg_q.push_back(nb[i]);
	endtask

	// one object: a few segments, each a handful of notes or a little noise
	task automatic send_object(input int forced_len);
		int   nseg, nnotes, noise;
		logic cut, tail_open;
		if (tx_jitter || rx_jitter || forced_len != 0) begin
			tx_jitter = ($urandom_range(0, 3) != 0);
			rx_jitter = ($urandom_range(0, 3) != 0);
		end
		nseg = (forced_len != 0) ? 1 : $urandom_range(1, 3);
		for (int s = 0; s < nseg; s++) begin
			seg_q.delete();
			if (forced_len == 0 && $urandom_range(0, 11) == 0) begin
				noise = $urandom_range(1, 8);
				repeat (noise) seg_q.push_back(8'($urandom_range(0, 255)));
			end else begin
				nnotes = (forced_len != 0) ? 1 : $urandom_range(1, 3);
				for (int n = 0; n < nnotes; n++) begin
					add_note((forced_len != 0) ? NK_BUILD_ID : pick_kind(), forced_len, cut);
					if (cut) break;
				end
			end
			// now and then the next object cuts in without a segment end
			tail_open = (s == nseg - 1) && forced_len == 0 && $urandom_range(0, 9) == 0;
			send_segment(s == 0, !tail_open);
			sent += seg_q.size();
		end
	endtask

	initial begin
		logic cut;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= 1'b0;
		note_if.valid <= 1'b0;
		note_if.data  <= '0;
		big_mode      = 1'b0;
		tx_jitter     = 1'b0;
		rx_jitter     = 1'b0;
		hold_len      = 0;
		sent          = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_mode(1'b0);

		// truncated header, then the shortest possible build id ending its segment
		seg_q = '{8'h00, 8'hFF, 8'h04, 8'h80, 8'h7F};
		send_segment(1'b1, 1'b1);
		seg_q.delete();
		add_note(NK_BUILD_ID, 1, cut);
		send_segment(1'b1, 1'b1);
		sent = DIRECTED_ITEMS;
		tx_jitter = 1'b1;
		rx_jitter = 1'b1;

		for (int phase = 0; phase < 4; phase++) begin
			if (phase != 0) begin
				settle();
				write_mode(phase % 2 == 1);
			end
			if (phase == 3) begin
				tx_jitter = 1'b0;
				rx_jitter = 1'b0;
			end
			if (phase == 1) begin
				// long id, then the receiver holds off while a new object waits
				send_object(70);
				hold_len = HOLD_OFF_LEN;
				send_object(0);
			end
			while (sent < DIRECTED_ITEMS + PHASE_ITEMS * (phase + 1)) send_object(0);
		end

		settle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
